FILE: design/sbc_pkg.sv
// shared types, round constants and hash functions of the sha-256 block compressor
package sbc_pkg;

    localparam int HASH_WORDS = 8;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS = 64;
    localparam int CFG_INDEX_W = 4;

    typedef logic [31:0] word_t;
    typedef logic [HASH_WORDS-1:0][31:0] hash_t;
    typedef logic [5:0] round_idx_t;

    // window control: shift in an input word or an expanded schedule word
    typedef struct packed {
        logic shift_word;
        logic shift_expand;
    } sched_ctl_t;

    // round unit control: load working variables or run one round
    typedef struct packed {
        logic load;
        logic step;
    } round_ctl_t;

    localparam hash_t HASH_RESET = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

FILE: design/sbc_sched.sv
// message schedule window: 16-word shift line with in-place expansion
module sbc_sched (
    input  logic                clk,
    input  sbc_pkg::sched_ctl_t ctl,
    input  sbc_pkg::word_t      word,
    output sbc_pkg::word_t      wt
);

    sbc_pkg::word_t window_reg [sbc_pkg::BLOCK_WORDS];
    sbc_pkg::word_t expand_next;

    // w[t+16] from the window holding w[t] .. w[t+15]
    assign expand_next = window_reg[0] + sbc_pkg::small_sigma0(window_reg[1])
                       + window_reg[9] + sbc_pkg::small_sigma1(window_reg[14]);

    assign wt = window_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctl.shift_word || ctl.shift_expand)
        begin
            for (int i = 0; i < sbc_pkg::BLOCK_WORDS - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[sbc_pkg::BLOCK_WORDS-1] <= ctl.shift_word ? word : expand_next;
        end
    end

endmodule

FILE: design/sbc_round.sv
// sha-256 round unit: working variables and one round per step
module sbc_round (
    input  logic                clk,
    input  sbc_pkg::round_ctl_t ctl,
    input  sbc_pkg::hash_t      seed,
    input  sbc_pkg::word_t      k,
    input  sbc_pkg::word_t      wt,
    output sbc_pkg::hash_t      vars
);

    sbc_pkg::hash_t v_reg;
    sbc_pkg::hash_t v_next;
    sbc_pkg::word_t t1;
    sbc_pkg::word_t t2;
    sbc_pkg::word_t ch;
    sbc_pkg::word_t maj;

    always_comb
    begin
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + sbc_pkg::big_sigma1(v_reg[4]) + ch + k + wt;
        t2  = sbc_pkg::big_sigma0(v_reg[0]) + maj;
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + t2;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            v_reg <= seed;
        end
        else if (ctl.step)
        begin
            v_reg <= v_next;
        end
    end

    assign vars = v_reg;

endmodule

FILE: design/sha256_block_compress.sv
// sha-256 block compressor top level: sequencer, chaining value and digest output
// order: the 16th word of a block starts ST_ROUND, then ST_ADD folds the result;
//   the first digest word is valid in ST_EMIT, which follows ST_ADD for a final block
// flow: in_stall holds off message words while a 512-bit block is compressed and,
//   after a final block, until the 8 digest words are taken
// reset: async active low; init hash registers return to the sha-256 values,
//   the next block starts a new message
module sha256_block_compress (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_write,
    input  logic [sbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    // message word channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [31:0]                     message_word,
    input  logic                            final_block,
    // digest channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     digest_word,
    output logic [2:0]                      digest_index,
    output logic                            digest_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;  // collecting message words
    localparam logic [1:0] ST_ROUND = 2'd1;  // running the 64 rounds
    localparam logic [1:0] ST_ADD   = 2'd2;  // folding working vars into chain
    localparam logic [1:0] ST_EMIT  = 2'd3;  // presenting the digest

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [3:0]          word_cnt_reg;
    logic [3:0]          word_cnt_next;
    sbc_pkg::round_idx_t round_cnt_reg;
    sbc_pkg::round_idx_t round_cnt_next;
    logic [2:0]          out_idx_reg;
    logic [2:0]          out_idx_next;
    logic                fresh_reg;
    logic                fresh_next;
    logic                final_reg;
    logic                final_next;

    sbc_pkg::hash_t      init_hash_reg;
    sbc_pkg::hash_t      chain_reg;
    sbc_pkg::hash_t      chain_next;
    sbc_pkg::hash_t      seed;
    sbc_pkg::hash_t      vars;
    sbc_pkg::word_t      wt;

    sbc_pkg::sched_ctl_t sched_ctl;
    sbc_pkg::round_ctl_t round_ctl;

    logic                in_xfer;
    logic                out_xfer;
    logic                block_done;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;

    // the sixteenth word of a block kicks off compression
    assign block_done = in_xfer && (word_cnt_reg == 4'(sbc_pkg::BLOCK_WORDS - 1));

    // first block of a message takes its chaining value from the init registers
    assign seed = fresh_reg ? init_hash_reg : chain_reg;

    always_comb
    begin
        sched_ctl.shift_word   = in_xfer;
        sched_ctl.shift_expand = (state_reg == ST_ROUND);
        round_ctl.load         = block_done;
        round_ctl.step         = (state_reg == ST_ROUND);
    end

    sbc_sched u_sched (
        .clk  (clk),
        .ctl  (sched_ctl),
        .word (message_word),
        .wt   (wt)
    );

    sbc_round u_round (
        .clk  (clk),
        .ctl  (round_ctl),
        .seed (seed),
        .k    (sbc_pkg::ROUND_K[round_cnt_reg]),
        .wt   (wt),
        .vars (vars)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        fresh_next     = fresh_reg;
        final_next     = final_reg;
        chain_next     = chain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    word_cnt_next = word_cnt_reg + 4'd1;
                end
                if (block_done)
                begin
                    // only the flag on the last word of a block counts
                    final_next     = final_block;
                    chain_next     = seed;
                    fresh_next     = 1'b0;
                    round_cnt_next = '0;
                    state_next     = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == 6'(sbc_pkg::ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < sbc_pkg::HASH_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                out_idx_next = '0;
                state_next   = final_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'(sbc_pkg::HASH_WORDS - 1))
                    begin
                        fresh_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            fresh_reg     <= 1'b1;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            fresh_reg     <= fresh_next;
            final_reg     <= final_next;
        end
    end

    // init hash registers; writes above the last index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_hash_reg <= sbc_pkg::HASH_RESET;
        end
        else if (cfg_write && (cfg_index < sbc_pkg::CFG_INDEX_W'(sbc_pkg::HASH_WORDS)))
        begin
            init_hash_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // chaining value is always seeded before it is read
    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
    end

    // digest words come straight from the chaining registers, stable while stalled
    assign digest_word  = chain_reg[out_idx_reg];
    assign digest_index = out_idx_reg;
    assign digest_last  = (out_idx_reg == 3'(sbc_pkg::HASH_WORDS - 1));

endmodule
